>>> sv/bwo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bwo_pkg;

    localparam int TABLE_SIZE  = 2048;
    localparam int BAND_COUNT  = 117;
    localparam int SAMPLE_BITS = 16;
    localparam int NOTE_COUNT  = 117;
    localparam int BANK_COUNT  = 4;
    localparam int BAND_LIMIT  = (BAND_COUNT < NOTE_COUNT) ? BAND_COUNT : NOTE_COUNT;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int FRAC_W  = 16;
    localparam int PHASE_W = IDX_W + FRAC_W;
    localparam int BAND_W  = 7;
    localparam int BANK_W  = $clog2(BANK_COUNT);
    localparam int FREQ_W  = 24;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = FREQ_W + SCALE_W;
    localparam int PV_W    = 17;
    localparam int REQ_W   = 2;
    localparam int IP_W    = SAMPLE_BITS + 1 + FRAC_W + 1;

    // tables split in even and odd entries so both neighbors are read in the same cycle
    localparam int HALF_AW    = BANK_W + BAND_W + IDX_W - 1;
    localparam int HALF_DEPTH = 2 ** HALF_AW;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd715828;
    localparam logic [PV_W-1:0]    PHASE_ONE   = 17'd65536;

    localparam logic [REQ_W-1:0] REQ_SAMPLE      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TABLE_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET_PHASE   = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SCALE     = 1'd1;

    // note frequencies in 1/256 Hz, rounded up
    localparam logic [FREQ_W-1:0] NOTE_Q8_CEIL [NOTE_COUNT] = '{
        4187, 4435, 4699, 4979, 5275, 5588, 5920, 6272, 6645, 7040,
        7459, 7903, 8373, 8870, 9398, 9957, 10549, 11176, 11840, 12544,
        13290, 14080, 14918, 15805, 16745, 17740, 18795, 19913, 21097, 22351,
        23680, 25088, 26580, 28160, 29835, 31609, 33489, 35480, 37590, 39825,
        42193, 44702, 47360, 50176, 53160, 56320, 59669, 63218, 66977, 70959,
        75179, 79649, 84385, 89403, 94719, 100351, 106319, 112640, 119338, 126435,
        133953, 141918, 150357, 159298, 168770, 178805, 189438, 200702, 212636, 225280,
        238676, 252869, 267905, 283836, 300713, 318595, 337539, 357610, 378875, 401404,
        425272, 450560, 477352, 505737, 535810, 567671, 601426, 637189, 675078, 715220,
        757749, 802807, 850544, 901120, 954704, 1011473, 1071619, 1135340, 1202851,
        1274377, 1350155, 1430439, 1515498, 1605614, 1701088, 1802240, 1909407,
        2022946, 2143237, 2270680, 2405702, 2548753, 2700309, 2860878, 3030995,
        3211227, 3402176
    };

    typedef struct packed {
        logic [REQ_W-1:0]              req_type;
        logic [FREQ_W-1:0]             frequency_q8;
        logic [BANK_W-1:0]             bank_index;
        logic [BAND_W-1:0]             band_index;
        logic [IDX_W-1:0]              entry_index;
        logic signed [SAMPLE_BITS-1:0] table_value;
        logic [PV_W-1:0]               phase_value;
    } t_req_item;

    typedef struct packed {
        logic                          we;
        logic                          odd;
        logic [HALF_AW-1:0]            addr;
        logic signed [SAMPLE_BITS-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic              vld;
        logic              bv;
        logic              odd;
        logic [FRAC_W-1:0] frac;
    } t_rd_tag;

    typedef struct packed {
        logic                          vld;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          band_selected;
    } t_result;

endpackage
`default_nettype wire

>>> sv/bwo_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bwo_req_if;
    import bwo_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [REQ_W-1:0]              req_type;
    logic [FREQ_W-1:0]             frequency_q8;
    logic [BANK_W-1:0]             bank_index;
    logic [BAND_W-1:0]             band_index;
    logic [IDX_W-1:0]              entry_index;
    logic signed [SAMPLE_BITS-1:0] table_value;
    logic [PV_W-1:0]               phase_value;

    modport source (
        output valid, req_type, frequency_q8, bank_index, band_index,
               entry_index, table_value, phase_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, frequency_q8, bank_index, band_index,
               entry_index, table_value, phase_value,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/bwo_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bwo_res_if;
    import bwo_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          band_selected;

    modport source (
        output valid, sample_out, band_selected,
        input  ready
    );

    modport sink (
        input  valid, sample_out, band_selected,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/bandlimited_wavetable_oscillator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel     direction  transfer when          payload
// i_req       in         valid && ready         req_type, frequency_q8, bank/band/entry,
//                                               table_value, phase_value
// o_res       out        valid && ready         sample_out, band_selected
// i_cfg_*     in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// one request per cycle while ready is high; a sample result passes the front stage
// registers, the table read with its tag register and the interpolation register,
// then enters the result queue and shows on o_res. table reads use an even and an odd
// memory so both neighbors come in the same cycle. up to 8 sample requests may be
// outstanding (result queue depth); ready drops while 8 are, so a stalled sink still
// lets 8 sample requests in. reset is synchronous; wavetable contents are not cleared.
module bandlimited_wavetable_oscillator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bwo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bwo_pkg::SCALE_W-1:0]   i_cfg_data,
    bwo_req_if.sink                            i_req,
    bwo_res_if.source                          o_res
);
    import bwo_pkg::*;

    t_req_item                     req;
    t_tbl_wr                       wr;
    t_rd_tag                       tag;
    t_result                       res;
    logic                          acc;
    logic                          acc_smp;
    logic                          room;
    logic                          pop;
    logic [HALF_AW-1:0]            raddr_even;
    logic [HALF_AW-1:0]            raddr_odd;
    logic [SAMPLE_BITS-1:0]        rd_even;
    logic [SAMPLE_BITS-1:0]        rd_odd;

    assign acc     = i_req.valid && room;
    assign acc_smp = acc && (i_req.req_type == REQ_SAMPLE);
    assign pop     = o_res.valid && o_res.ready;

    assign i_req.ready = room;

    always_comb begin
        req.req_type     = i_req.req_type;
        req.frequency_q8 = i_req.frequency_q8;
        req.bank_index   = i_req.bank_index;
        req.band_index   = i_req.band_index;
        req.entry_index  = i_req.entry_index;
        req.table_value  = i_req.table_value;
        req.phase_value  = i_req.phase_value;
    end

    bwo_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (acc),
        .i_req        (req),
        .o_wr         (wr),
        .o_raddr_even (raddr_even),
        .o_raddr_odd  (raddr_odd),
        .o_tag        (tag)
    );

    bwo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (wr.we && !wr.odd),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr_even),
        .o_rdata (rd_even)
    );

    bwo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (wr.we && wr.odd),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr_odd),
        .o_rdata (rd_odd)
    );

    bwo_interp u_interp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (tag),
        .i_rd_even ($signed(rd_even)),
        .i_rd_odd  ($signed(rd_odd)),
        .o_res     (res)
    );

    bwo_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc_smp  (acc_smp),
        .i_push     (res),
        .i_pop      (pop),
        .o_room     (room),
        .o_valid    (o_res.valid),
        .o_sample   (o_res.sample_out),
        .o_band_sel (o_res.band_selected)
    );
endmodule
`default_nettype wire

>>> sv/bwo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old entry when the same address is written at that edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/bwo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bwo_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bwo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bwo_pkg::SCALE_W-1:0]      i_cfg_data,
    input  wire logic                             i_acc,
    input  wire bwo_pkg::t_req_item               i_req,
    output bwo_pkg::t_tbl_wr                      o_wr,
    output logic [bwo_pkg::HALF_AW-1:0]           o_raddr_even,
    output logic [bwo_pkg::HALF_AW-1:0]           o_raddr_odd,
    output bwo_pkg::t_rd_tag                      o_tag
);
    import bwo_pkg::*;

    logic [BANK_W-1:0]  r_wsel;
    logic [SCALE_W-1:0] r_scale;
    logic [FREQ_W-1:0]  r_last_freq;
    logic               r_band_valid;

    // front stage, registered at the input transfer
    logic                  r_a_smp;
    logic                  r_a_new;
    logic                  r_a_bv;
    logic                  r_a_set;
    logic [PROD_W-1:0]     r_a_prod;
    logic [BAND_LIMIT-1:0] r_a_cmp;
    logic [PHASE_W-1:0]    r_a_setv;

    // oscillator state
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] r_step;
    logic [BAND_W-1:0]  r_band;
    t_rd_tag            r_tag;

    logic                  is_smp;
    logic                  new_freq;
    logic                  set_ok;
    logic [BAND_LIMIT-1:0] n_cmp;
    logic [PHASE_W-1:0]    n_setv;
    logic [BAND_W-1:0]     band_sel;
    logic [BAND_W-1:0]     band_k;
    logic [PHASE_W-1:0]    step_sat;
    logic [PHASE_W-1:0]    step_k;
    logic [IDX_W-1:0]      i0;
    logic [IDX_W-1:0]      i1;

    assign is_smp   = i_acc && (i_req.req_type == REQ_SAMPLE);
    assign new_freq = is_smp && (i_req.frequency_q8 != '0)
                      && (i_req.frequency_q8 != r_last_freq);
    assign set_ok   = i_req.phase_value <= PHASE_ONE;
    assign n_setv   = PHASE_W'((PV_W + IDX_W)'(i_req.phase_value)
                               * (PV_W + IDX_W)'(TABLE_SIZE - 1));

    always_comb begin
        for (int i = 0; i < BAND_LIMIT; i++) begin
            n_cmp[i] = i_req.frequency_q8 <= NOTE_Q8_CEIL[i];
        end
    end

    // table writes go straight to the memories at the transfer edge
    always_comb begin
        o_wr.we   = i_acc && (i_req.req_type == REQ_TABLE_WRITE)
                    && ((BAND_W + 1)'(i_req.band_index) < (BAND_W + 1)'(BAND_COUNT))
                    && ((IDX_W + 1)'(i_req.entry_index) < (IDX_W + 1)'(TABLE_SIZE));
        o_wr.odd  = i_req.entry_index[0];
        o_wr.addr = {i_req.bank_index, i_req.band_index, i_req.entry_index[IDX_W-1:1]};
        o_wr.data = i_req.table_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel       <= '0;
            r_scale      <= SCALE_RESET;
            r_last_freq  <= '0;
            r_band_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_WAVEFORM_SELECT)) begin
                r_wsel <= i_cfg_data[BANK_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_PHASE_SCALE)) begin
                r_scale     <= i_cfg_data;
                r_last_freq <= '0;
            end else if (new_freq) begin
                r_last_freq <= i_req.frequency_q8;
            end
            if (new_freq) begin
                r_band_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_smp <= 1'b0;
            r_a_new <= 1'b0;
            r_a_bv  <= 1'b0;
            r_a_set <= 1'b0;
        end else begin
            r_a_smp <= is_smp;
            r_a_new <= new_freq;
            r_a_bv  <= r_band_valid || new_freq;
            r_a_set <= i_acc && (i_req.req_type == REQ_SET_PHASE) && set_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_a_prod <= PROD_W'(i_req.frequency_q8) * PROD_W'(r_scale);
            r_a_cmp  <= n_cmp;
            r_a_setv <= n_setv;
        end
    end

    // thresholds rise with the index, so the lowest set compare wins
    always_comb begin
        band_sel = BAND_W'(BAND_LIMIT - 1);
        for (int i = BAND_LIMIT - 1; i >= 0; i--) begin
            if (r_a_cmp[i]) begin
                band_sel = BAND_W'(i);
            end
        end
    end

    assign step_sat = (r_a_prod[PROD_W-1:PHASE_W+16] != '0) ? '1
                      : r_a_prod[PHASE_W+15:16];
    assign step_k   = r_a_new ? step_sat : r_step;
    assign band_k   = r_a_new ? band_sel : r_band;

    assign i0 = r_phase[PHASE_W-1:FRAC_W];
    assign i1 = i0 + 1'b1;

    assign o_raddr_odd  = {r_wsel, band_k, i0[IDX_W-1:1]};
    assign o_raddr_even = {r_wsel, band_k, (i0[0] ? i1[IDX_W-1:1] : i0[IDX_W-1:1])};

    always_comb begin
        n_phase = r_phase;
        if (r_a_set) begin
            n_phase = r_a_setv;
        end else if (r_a_smp && r_a_bv) begin
            n_phase = r_phase + step_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_band    <= '0;
            r_tag.vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_step    <= step_k;
            r_band    <= band_k;
            r_tag.vld <= r_a_smp;
        end
        r_tag.bv   <= r_a_bv;
        r_tag.odd  <= i0[0];
        r_tag.frac <= r_phase[FRAC_W-1:0];
    end

    assign o_tag = r_tag;
endmodule
`default_nettype wire

>>> sv/bwo_interp.sv
`timescale 1ns / 1ps
`default_nettype none
module bwo_interp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bwo_pkg::t_rd_tag                     i_tag,
    input  wire logic signed [bwo_pkg::SAMPLE_BITS-1:0] i_rd_even,
    input  wire logic signed [bwo_pkg::SAMPLE_BITS-1:0] i_rd_odd,
    output bwo_pkg::t_result                          o_res
);
    import bwo_pkg::*;

    logic signed [SAMPLE_BITS-1:0] v0;
    logic signed [SAMPLE_BITS-1:0] v1;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [IP_W-1:0]        n_prod;

    logic                          r_c_vld;
    logic                          r_c_bv;
    logic signed [IP_W-1:0]        r_c_prod;
    logic signed [SAMPLE_BITS-1:0] r_c_v0;

    logic signed [IP_W:0]          rnd;
    logic signed [IP_W:0]          shf;

    assign v0     = i_tag.odd ? i_rd_odd : i_rd_even;
    assign v1     = i_tag.odd ? i_rd_even : i_rd_odd;
    assign diff   = (SAMPLE_BITS + 1)'(v1) - (SAMPLE_BITS + 1)'(v0);
    assign n_prod = IP_W'(diff) * $signed({1'b0, i_tag.frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_bv   <= i_tag.bv;
        r_c_prod <= n_prod;
        r_c_v0   <= v0;
    end

    // round half up, then floor through the arithmetic shift
    assign rnd = (IP_W + 1)'(r_c_prod) + (IP_W + 1)'(1 << (FRAC_W - 1));
    assign shf = rnd >>> FRAC_W;

    always_comb begin
        o_res.vld           = r_c_vld;
        o_res.band_selected = r_c_bv;
        o_res.sample        = r_c_bv ? (r_c_v0 + shf[SAMPLE_BITS-1:0]) : '0;
    end
endmodule
`default_nettype wire

>>> sv/bwo_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module bwo_outq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_acc_smp,
    input  wire bwo_pkg::t_result            i_push,
    input  wire logic                        i_pop,
    output logic                             o_room,
    output logic                             o_valid,
    output logic signed [bwo_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                             o_band_sel
);
    import bwo_pkg::*;

    logic [SAMPLE_BITS:0] r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   r_wp;
    logic [OUTQ_AW-1:0]   r_rp;
    logic [OUTQ_CW-1:0]   r_cnt;
    logic [OUTQ_CW-1:0]   r_pend;

    // r_pend counts sample requests taken in whose result has not left yet,
    // so the queue can never overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (i_push.vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt  <= r_cnt + OUTQ_CW'(i_push.vld) - OUTQ_CW'(i_pop);
            r_pend <= r_pend + OUTQ_CW'(i_acc_smp) - OUTQ_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wp] <= {i_push.band_selected, i_push.sample};
        end
    end

    assign o_room     = r_pend < OUTQ_CW'(OUTQ_DEPTH);
    assign o_valid    = r_cnt != '0;
    assign o_sample   = r_mem[r_rp][SAMPLE_BITS-1:0];
    assign o_band_sel = r_mem[r_rp][SAMPLE_BITS];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.vld && !i_pop) |-> (r_cnt < OUTQ_CW'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_cnt_le_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pend)
        else $error("queued results exceed outstanding requests");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("too many sample requests in flight");
endmodule
`default_nettype wire

>>> sim/bwo_sample_checker.sv
`timescale 1ns / 1ps
module bwo_sample_checker
    import bwo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    bwo_req_if                   i_req,
    bwo_res_if                   i_res,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          band_sel;
    } t_sample_exp;

    // shadow of the wavetables, only entries that were written
    logic signed [SAMPLE_BITS-1:0] wave_mem [int];

    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [FREQ_W-1:0]  prev_freq;
    logic [BAND_W-1:0]  band;
    logic               have_band;
    logic [BANK_W-1:0]  bank_sel;
    logic [SCALE_W-1:0] scale;

    t_sample_exp expected_samples [$];

    function automatic int mem_key(input logic [BANK_W-1:0] bk, input logic [BAND_W-1:0] bd,
                                   input logic [IDX_W-1:0] idx);
        return (int'(bk) * BAND_COUNT + int'(bd)) * TABLE_SIZE + int'(idx);
    endfunction

    function automatic longint table_entry(input logic [IDX_W-1:0] idx);
        int k;
        k = mem_key(bank_sel, band, idx);
        return wave_mem.exists(k) ? longint'(wave_mem[k]) : 64'sd0;
    endfunction

    function automatic logic [BAND_W-1:0] band_for_freq(input logic [FREQ_W-1:0] f);
        for (int i = 0; i < BAND_LIMIT; i++) begin
            if (NOTE_Q8_CEIL[i] >= f)
                return BAND_W'(i);
        end
        return BAND_W'(BAND_LIMIT - 1);
    endfunction

    // round half up between the two neighbors; last entry pairs with entry 0
    function automatic logic signed [SAMPLE_BITS-1:0] lerp_at(input logic [PHASE_W-1:0] ph);
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] i1;
        longint           v0;
        longint           v1;
        longint           acc;
        i0  = ph[PHASE_W-1:FRAC_W];
        i1  = (i0 == IDX_W'(TABLE_SIZE - 1)) ? '0 : i0 + 1'b1;
        v0  = table_entry(i0);
        v1  = table_entry(i1);
        acc = (v1 - v0) * longint'(ph[FRAC_W-1:0]) + 64'sd32768;
        return SAMPLE_BITS'(v0 + (acc >>> FRAC_W));
    endfunction

    task automatic note_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic apply_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [SCALE_W-1:0] data);
        case (idx)
            CFG_WAVEFORM_SELECT: begin
                bank_sel = data[BANK_W-1:0];
            end
            CFG_PHASE_SCALE: begin
                scale     = data;
                prev_freq = '0;
            end
            default: ;
        endcase
    endtask

    task automatic apply_request();
        logic [PROD_W-1:0] prod;
        t_sample_exp       e;
        case (i_req.req_type)
            REQ_TABLE_WRITE: begin
                if (i_req.band_index < BAND_COUNT)
                    wave_mem[mem_key(i_req.bank_index, i_req.band_index, i_req.entry_index)] =
                        i_req.table_value;
            end
            REQ_SET_PHASE: begin
                if (i_req.phase_value <= PHASE_ONE)
                    phase = PHASE_W'(int'(i_req.phase_value) * (TABLE_SIZE - 1));
            end
            REQ_SAMPLE: begin
                if (i_req.frequency_q8 != '0 && i_req.frequency_q8 != prev_freq) begin
                    prod = PROD_W'(i_req.frequency_q8) * PROD_W'(scale);
                    if (|prod[PROD_W-1:FRAC_W+PHASE_W])
                        step = '1;
                    else
                        step = prod[FRAC_W+PHASE_W-1:FRAC_W];
                    band      = band_for_freq(i_req.frequency_q8);
                    prev_freq = i_req.frequency_q8;
                    have_band = 1'b1;
                end
                if (!have_band) begin
                    e.sample   = '0;
                    e.band_sel = 1'b0;
                end else begin
                    e.sample   = lerp_at(phase);
                    e.band_sel = 1'b1;
                    // phase span is a power of two, so the wrap is the natural overflow
                    phase = phase + step;
                end
                expected_samples.push_back(e);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_sample_exp e;
        if (!i_rst_n) begin
            phase     = '0;
            step      = '0;
            prev_freq = '0;
            band      = '0;
            have_band = 1'b0;
            bank_sel  = '0;
            scale     = SCALE_RESET;
            expected_samples.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            // results first, so a transfer in this cycle cannot hide a stray result
            if (i_res.valid && i_res.ready) begin
                if (expected_samples.size() == 0) begin
                    note_mismatch($sformatf("unexpected result sample %0d band %0b",
                                            i_res.sample_out, i_res.band_selected));
                end else begin
                    e = expected_samples.pop_front();
                    o_checked++;
                    if (i_res.sample_out !== e.sample || i_res.band_selected !== e.band_sel)
                        note_mismatch($sformatf(
                            "sample expected %0d band %0b, got %0d band %0b",
                            e.sample, e.band_sel, i_res.sample_out, i_res.band_selected));
                end
            end
            if (i_cfg_we)
                apply_cfg_write(i_cfg_idx, i_cfg_data);
            if (i_req.valid && i_req.ready)
                apply_request();
        end
        o_pending = expected_samples.size();
    end

endmodule

>>> sim/bandlimited_wavetable_oscillator_tb.sv
`timescale 1ns / 1ps
module bandlimited_wavetable_oscillator_tb;
    import bwo_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CHUNK_ITEMS   = 50;
    localparam int SETTING_COUNT = 6;

    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

    // only this bank and band get a full table, and only frequencies mapping to it are played
    localparam int PLAY_BANK = 2;
    localparam int PLAY_BAND = 0;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [SCALE_W-1:0] cfg_data;
    logic               sink_ready = 1'b0;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int ready_hold  = 0;
    int stall_roll;
    int sent_items   = 0;
    int sent_samples = 0;
    int sent_writes  = 0;
    int settings_done = 0;
    bit gaps_on = 1'b0;
    logic [FREQ_W-1:0] last_freq_sent = '0;

    bwo_req_if req_if ();
    bwo_res_if res_if ();

    assign res_if.ready = sink_ready;

    bandlimited_wavetable_oscillator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    bwo_sample_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: runs of ready and stalls, mostly short, some long, some long open stretches
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            stall_roll = $urandom_range(99);
            if (stall_roll < 55) begin
                sink_ready <= 1'b1;
                ready_hold <= $urandom_range(8, 0);
            end else if (stall_roll < 60) begin
                sink_ready <= 1'b1;
                ready_hold <= $urandom_range(300, 50);
            end else if (stall_roll < 95) begin
                sink_ready <= 1'b0;
                ready_hold <= $urandom_range(2, 0);
            end else begin
                sink_ready <= 1'b0;
                ready_hold <= $urandom_range(40, 10);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bandlimited_wavetable_oscillator test failed");
        $finish;
    end

    function automatic t_req_item noise_item();
        t_req_item it;
        it.req_type     = REQ_IGNORED;
        it.frequency_q8 = FREQ_W'($urandom);
        it.bank_index   = BANK_W'($urandom);
        it.band_index   = BAND_W'($urandom);
        it.entry_index  = IDX_W'($urandom);
        it.table_value  = SAMPLE_BITS'($urandom);
        it.phase_value  = PV_W'($urandom);
        return it;
    endfunction

    function automatic logic [FREQ_W-1:0] freq_in_band(input int b);
        int lo;
        int hi;
        lo = (b == 0) ? 1 : int'(NOTE_Q8_CEIL[b-1]) + 1;
        hi = (b == BAND_LIMIT - 1) ? (1 << FREQ_W) - 1 : int'(NOTE_Q8_CEIL[b]);
        return FREQ_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] wave_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'sh7fff;
        else if (r < 20)
            return 16'sh8000;
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return '0;
        else if (r < 35)
            return last_freq_sent;
        return freq_in_band(PLAY_BAND);
    endfunction

    // valid stays high across back-to-back transfers; only a pause or a drain lowers it
    task automatic send(input t_req_item it);
        req_if.valid        <= 1'b1;
        req_if.req_type     <= it.req_type;
        req_if.frequency_q8 <= it.frequency_q8;
        req_if.bank_index   <= it.bank_index;
        req_if.band_index   <= it.band_index;
        req_if.entry_index  <= it.entry_index;
        req_if.table_value  <= it.table_value;
        req_if.phase_value  <= it.phase_value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_sample(input logic [FREQ_W-1:0] f);
        t_req_item it;
        it = noise_item();
        it.req_type     = REQ_SAMPLE;
        it.frequency_q8 = f;
        send(it);
        sent_samples++;
        if (f != '0)
            last_freq_sent = f;
    endtask

    task automatic send_write(input int bk, input int bd, input int idx,
                              input logic signed [SAMPLE_BITS-1:0] val);
        t_req_item it;
        it = noise_item();
        it.req_type    = REQ_TABLE_WRITE;
        it.bank_index  = BANK_W'(bk);
        it.band_index  = BAND_W'(bd);
        it.entry_index = IDX_W'(idx);
        it.table_value = val;
        send(it);
        sent_writes++;
    endtask

    task automatic send_phase(input int pv);
        t_req_item it;
        it = noise_item();
        it.req_type    = REQ_SET_PHASE;
        it.phase_value = PV_W'(pv);
        send(it);
    endtask

    task automatic pause(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        int r;
        if (gaps_on) begin
            r = $urandom_range(99);
            if (r < 3)
                pause($urandom_range(40, 10));
            else if (r < 25)
                pause($urandom_range(3, 1));
        end
    endtask

    // hold the sender until every sample is back, let in-flight writes settle
    task automatic drain();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [BANK_W-1:0] wsel,
                                  input logic [SCALE_W-1:0] scl);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WAVEFORM_SELECT;
        cfg_data <= SCALE_W'(wsel);
        @(posedge clk);
        cfg_idx  <= CFG_PHASE_SCALE;
        cfg_data <= scl;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_done++;
    endtask

    function automatic logic [SCALE_W-1:0] scale_for(input int k);
        case (k)
            0: return 32'hffff_ffff;
            1: return 32'd0;
            2: return SCALE_W'($urandom);
            3: return SCALE_W'($urandom_range(3_000_000, 1));
            4: return 32'd1;
            default: return SCALE_RESET;
        endcase
    endfunction

    initial begin
        int n;
        int done_items;
        int r;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_WAVEFORM_SELECT;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_SAMPLE;
        req_if.frequency_q8 <= '0;
        req_if.bank_index   <= '0;
        req_if.band_index   <= '0;
        req_if.entry_index  <= '0;
        req_if.table_value  <= '0;
        req_if.phase_value  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any band: zero output, phase frozen; odd requests ignored
        send_sample('0);
        send(noise_item());
        send_phase((1 << PV_W) - 1);
        send_phase(int'(PHASE_ONE) + 1);
        send_write(3, (1 << BAND_W) - 1, TABLE_SIZE - 1, 16'sh7fff);
        send_sample('0);

        // fill the table that playback reads
        for (int e = 0; e < TABLE_SIZE; e++)
            send_write(PLAY_BANK, PLAY_BAND, e, wave_value());
        // full-scale step across the wrap from the last entry to the first
        send_write(PLAY_BANK, PLAY_BAND, TABLE_SIZE - 1, 16'sh7fff);
        send_write(PLAY_BANK, PLAY_BAND, 0, 16'sh8000);
        send_write(PLAY_BANK, PLAY_BAND, 1, 16'sh7fff);
        write_settings(BANK_W'(PLAY_BANK), SCALE_RESET);

        send_phase(int'(PHASE_ONE));
        send_sample(freq_in_band(PLAY_BAND));
        send_sample('0);
        send_sample(FREQ_W'(NOTE_Q8_CEIL[0]));
        send_phase(0);
        send_sample(FREQ_W'(1));
        send_sample(FREQ_W'(NOTE_Q8_CEIL[0]) - 1'b1);
        send_sample('0);
        send_phase(int'(PHASE_ONE) / 2);
        send_sample('0);

        for (int k = 0; k < SETTING_COUNT; k++) begin
            write_settings(BANK_W'(PLAY_BANK), scale_for(k));
            // same frequency again must pick up the new scale
            send_sample(last_freq_sent);
            n = 0;
            done_items = 0;
            while (done_items < CHUNK_ITEMS) begin
                if (n % 50 == 0)
                    gaps_on = ($urandom_range(3) != 0);
                n++;
                maybe_gap();
                r = $urandom_range(99);
                if (r < 60) begin
                    send_sample(pick_freq());
                    done_items++;
                end else if (r < 70) begin
                    send_phase($urandom_range(int'(PHASE_ONE)));
                    done_items++;
                end else if (r < 72) begin
                    send_phase($urandom_range((1 << PV_W) - 1, int'(PHASE_ONE) + 1));
                end else if (r < 94) begin
                    send_write($urandom_range(BANK_COUNT - 1), $urandom_range((1 << BAND_W) - 1),
                               $urandom_range(TABLE_SIZE - 1), wave_value());
                    done_items++;
                end else begin
                    send(noise_item());
                end
            end
        end

        drain();
        $display("run covered %0d requests: %0d samples checked, %0d table writes, %0d settings",
                 sent_items, checked, sent_writes, settings_done);
        $display("samples sent %0d, mismatches %0d", sent_samples, mismatches);
        if (mismatches == 0)
            $display("bandlimited_wavetable_oscillator test passed");
        else
            $display("bandlimited_wavetable_oscillator test failed");
        $finish;
    end

endmodule

>>> files.f
sv/bwo_pkg.sv
sv/bwo_req_if.sv
sv/bwo_res_if.sv
sv/bwo_ram.sv
sv/bwo_ctrl.sv
sv/bwo_interp.sv
sv/bwo_outq.sv
sv/bandlimited_wavetable_oscillator.sv
sim/bwo_sample_checker.sv
sim/bandlimited_wavetable_oscillator_tb.sv
